>>> sv/cpdb_pkg.sv
// Shared types, codes and neighbor-word helpers for the cubic planar dual builder.
// No dependencies; imported by cubic_planar_dual_builder, dual_scoreboard and testbench.
package cpdb_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_CHK_RD,
        S_CHK_CK,
        S_MAIN_RD,
        S_MAIN_GET,
        S_USE,
        S_NUM,
        S_NUM2,
        S_FCHK,
        S_FCHK2,
        S_W_LOOP,
        S_W_TEST,
        S_W_NB,
        S_ECHK,
        S_A_RS,
        S_A_GS,
        S_A_RA,
        S_A_RB,
        S_A_NB,
        S_A_P,
        S_A_W,
        S_FIN,
        S_R_RS,
        S_R_GS,
        S_R_RA,
        S_R_RB,
        S_R_NB,
        S_R_P,
        S_R_E,
        S_R_OUT
    } t_state;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_BACK   = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_BAD_EDGES = 3'd3;
    localparam logic [2:0] ST_NO_FACE   = 3'd4;

    localparam logic [1:0] SLOT_NONE       = 2'd3;
    localparam logic [7:0] FACE_UNASSIGNED = 8'hFF;
    localparam logic [2:0] SIZE_PENT       = 3'd5;
    localparam logic [2:0] SIZE_HEX        = 3'd6;

    // width of edge, slot and clearing counters (holds three times 256)
    localparam int CNT_W = 10;

    function automatic logic [7:0] nb_byte(input logic [23:0] nb, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = nb[7:0];
            2'd1:    r = nb[15:8];
            2'd2:    r = nb[23:16];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // first slot of an adjacency word that holds target
    function automatic logic [1:0] slot_find(input logic [23:0] nb, input logic [7:0] target);
        logic [1:0] r;
        priority if (nb[7:0] == target)   r = 2'd0;
        else if     (nb[15:8] == target)  r = 2'd1;
        else if     (nb[23:16] == target) r = 2'd2;
        else                              r = SLOT_NONE;
        return r;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] q);
        return (q == 2'd2) ? 2'd0 : q + 2'd1;
    endfunction

endpackage

>>> sv/cubic_planar_dual_builder.sv
// Top level of the cubic planar dual builder: loads adjacency, builds the dual, serves face reads.
// Depends on cpdb_pkg; its graph and face tables live in six block memories inside this module.
//
// A cubic planar graph arrives one vertex per transfer (tuser 0), neighbors in clockwise
// order. The transfer with tlast set starts the build, which runs on a sequencer around
// registered-read memories: a clearing pass over the slot stores, a range check of the
// neighbor indices, then edge numbering, face tracing and dual linking, ending in a
// single status transfer. A read transfer (tuser 1) fetches the face size, then returns
// one result per boundary position of the requested face, the run closed by tlast, or
// one status-4 result if the face does not exist. The input is not ready during a build
// or a read run, or while a result waits in the output register and the receiver holds
// off; a held result adds its stall cycles to the run.
module cubic_planar_dual_builder #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // vertex_index[7:0], neighbor_first[15:8], neighbor_second[23:16],
    // neighbor_third[31:24], face_to_read[39:32]
    input  logic [39:0] i_s_tdata,
    // action[0]
    input  logic        i_s_tuser,
    // final_vertex
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // face_count[7:0], edge_count[16:8], face_index[24:17], position[27:25],
    // face_vertex[35:28], adjacent_face[43:36], edge_index[52:44], face_len[55:53]
    output logic [55:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]  o_m_tuser,
    // last_of_run
    output logic        o_m_tlast
);
    import cpdb_pkg::*;

    localparam int NV     = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int NF     = MAX_VERTICES / 2 + 2;
    localparam int NFS    = (NF < 154) ? NF : 154;
    localparam int NF_LIM = (NF < 255) ? NF : 255;
    localparam int ME     = 3 * MAX_VERTICES / 2;
    localparam int ME_LIM = (ME < 1023) ? ME : 1023;
    localparam int VA     = $clog2(NV);
    localparam int SA     = $clog2(3 * NV);
    localparam int FA     = $clog2(NFS);
    localparam int FVA    = $clog2(6 * NFS);

    function automatic logic [SA-1:0] slot_addr(input logic [7:0] vtx, input logic [1:0] p);
        logic [9:0] t;
        t = {1'b0, vtx, 1'b0} + {2'b00, vtx} + {8'd0, p};
        return t[SA-1:0];
    endfunction

    function automatic logic [FVA-1:0] face_addr(input logic [7:0] fid, input logic [2:0] p);
        logic [10:0] t;
        t = {1'b0, fid, 2'b00} + {2'b00, fid, 1'b0} + {8'd0, p};
        return t[FVA-1:0];
    endfunction

    // input fields
    logic       s_action;
    logic [7:0] s_vi, s_n1, s_n2, s_n3, s_fr;
    logic       s_final;
    assign s_action = i_s_tuser;
    assign s_vi     = i_s_tdata[7:0];
    assign s_n1     = i_s_tdata[15:8];
    assign s_n2     = i_s_tdata[23:16];
    assign s_n3     = i_s_tdata[31:24];
    assign s_fr     = i_s_tdata[39:32];
    assign s_final  = i_s_tlast;

    // memories
    logic [23:0] r_nb_mem [NV];
    logic [7:0]  r_sf_mem [3*NV];
    logic [8:0]  r_se_mem [3*NV];
    logic [7:0]  r_fv_mem [6*NFS];
    logic [7:0]  r_fa_mem [6*NFS];
    logic [2:0]  r_fs_mem [NFS];

    logic [23:0] r_nb_rd;
    logic [7:0]  r_sf_rd, r_fv_rd, r_fa_rd;
    logic [8:0]  r_se_rd;
    logic [2:0]  r_fs_rd;

    logic           nb_we;
    logic [VA-1:0]  nb_wa, nb_ra;
    logic [23:0]    nb_wd;
    logic           sf_we;
    logic [SA-1:0]  sf_wa, sf_ra;
    logic [7:0]     sf_wd;
    logic           se_we;
    logic [SA-1:0]  se_wa, se_ra;
    logic [8:0]     se_wd;
    logic           fv_we;
    logic [FVA-1:0] fv_wa, fv_ra;
    logic [7:0]     fv_wd;
    logic           fa_we;
    logic [FVA-1:0] fa_wa, fa_ra;
    logic [7:0]     fa_wd;
    logic           fs_we;
    logic [FA-1:0]  fs_wa, fs_ra;
    logic [2:0]     fs_wd;

    always_ff @(posedge i_clk) begin
        if (nb_we) r_nb_mem[nb_wa] <= nb_wd;
        r_nb_rd <= r_nb_mem[nb_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sf_we) r_sf_mem[sf_wa] <= sf_wd;
        r_sf_rd <= r_sf_mem[sf_ra];
    end
    always_ff @(posedge i_clk) begin
        if (se_we) r_se_mem[se_wa] <= se_wd;
        r_se_rd <= r_se_mem[se_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fv_we) r_fv_mem[fv_wa] <= fv_wd;
        r_fv_rd <= r_fv_mem[fv_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fa_we) r_fa_mem[fa_wa] <= fa_wd;
        r_fa_rd <= r_fa_mem[fa_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fs_we) r_fs_mem[fs_wa] <= fs_wd;
        r_fs_rd <= r_fs_mem[fs_ra];
    end

    // control and working registers
    t_state           r_state, n_state;
    logic [8:0]       r_n, n_n;
    logic [8:0]       r_v, n_v;
    logic [1:0]       r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic [23:0]      r_nbv, n_nbv;
    logic [7:0]       r_u, n_u, r_a, n_a, r_b, n_b;
    logic [1:0]       r_pos, n_pos;
    logic [2:0]       r_size, n_size;
    logic [7:0]       r_faces, n_faces;
    logic [CNT_W-1:0] r_edges, n_edges;
    logic [2:0]       r_st, n_st;
    logic [7:0]       r_f, n_f;
    logic [2:0]       r_s, n_s, r_pj, n_pj;
    logic [7:0]       r_fr, n_fr, r_adj, n_adj;
    logic [8:0]       r_ei, n_ei;

    logic [2:0]       r_sum_st, n_sum_st;
    logic [7:0]       r_sum_faces, n_sum_faces;
    logic [CNT_W-1:0] r_sum_edges, n_sum_edges;

    logic             r_ovalid, n_ovalid;
    logic [2:0]       r_o_status, n_o_status;
    logic [7:0]       r_o_fi, n_o_fi, r_o_fv, n_o_fv, r_o_adj, n_o_adj;
    logic [2:0]       r_o_pos, n_o_pos, r_o_fs, n_o_fs;
    logic [8:0]       r_o_ei, n_o_ei;
    logic             r_o_last, n_o_last;

    logic             o_free, s_xfer;
    logic [CNT_W-1:0] three_n;
    logic             last_v;
    logic [2:0]       pj_next;
    logic [1:0]       c_p;

    assign o_free     = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && o_free;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign three_n    = {r_n, 1'b0} + {1'b0, r_n};
    assign last_v     = (r_v == r_n - 9'd1);
    assign pj_next    = (r_pj + 3'd1 == r_s) ? 3'd0 : r_pj + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_sum_st    <= ST_OK;
            r_sum_faces <= '0;
            r_sum_edges <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_sum_st    <= n_sum_st;
            r_sum_faces <= n_sum_faces;
            r_sum_edges <= n_sum_edges;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_j        <= n_j;
        r_k        <= n_k;
        r_nbv      <= n_nbv;
        r_u        <= n_u;
        r_a        <= n_a;
        r_b        <= n_b;
        r_pos      <= n_pos;
        r_size     <= n_size;
        r_faces    <= n_faces;
        r_edges    <= n_edges;
        r_st       <= n_st;
        r_f        <= n_f;
        r_s        <= n_s;
        r_pj       <= n_pj;
        r_fr       <= n_fr;
        r_adj      <= n_adj;
        r_ei       <= n_ei;
        r_o_status <= n_o_status;
        r_o_fi     <= n_o_fi;
        r_o_pos    <= n_o_pos;
        r_o_fv     <= n_o_fv;
        r_o_adj    <= n_o_adj;
        r_o_ei     <= n_o_ei;
        r_o_fs     <= n_o_fs;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_v         = r_v;
        n_j         = r_j;
        n_k         = r_k;
        n_nbv       = r_nbv;
        n_u         = r_u;
        n_a         = r_a;
        n_b         = r_b;
        n_pos       = r_pos;
        n_size      = r_size;
        n_faces     = r_faces;
        n_edges     = r_edges;
        n_st        = r_st;
        n_f         = r_f;
        n_s         = r_s;
        n_pj        = r_pj;
        n_fr        = r_fr;
        n_adj       = r_adj;
        n_ei        = r_ei;
        n_sum_st    = r_sum_st;
        n_sum_faces = r_sum_faces;
        n_sum_edges = r_sum_edges;
        n_ovalid    = r_ovalid && !i_m_tready;
        n_o_status  = r_o_status;
        n_o_fi      = r_o_fi;
        n_o_pos     = r_o_pos;
        n_o_fv      = r_o_fv;
        n_o_adj     = r_o_adj;
        n_o_ei      = r_o_ei;
        n_o_fs      = r_o_fs;
        n_o_last    = r_o_last;
        c_p         = SLOT_NONE;

        nb_we = 1'b0; nb_wa = '0; nb_wd = '0; nb_ra = '0;
        sf_we = 1'b0; sf_wa = '0; sf_wd = '0; sf_ra = '0;
        se_we = 1'b0; se_wa = '0; se_wd = '0; se_ra = '0;
        fv_we = 1'b0; fv_wa = '0; fv_wd = '0; fv_ra = '0;
        fa_we = 1'b0; fa_wa = '0; fa_wd = '0; fa_ra = '0;
        fs_we = 1'b0; fs_wa = '0; fs_wd = '0; fs_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_action == ACT_LOAD) begin
                        if ({1'b0, s_vi} < 9'(NV)) begin
                            nb_we = 1'b1;
                            nb_wa = s_vi[VA-1:0];
                            nb_wd = {s_n3, s_n2, s_n1};
                            n_n   = {1'b0, s_vi} + 9'd1;
                            if (s_final) begin
                                n_k     = '0;
                                n_faces = '0;
                                n_edges = '0;
                                n_st    = ST_OK;
                                n_state = S_CLR;
                            end
                        end
                    end else begin
                        n_fr = s_fr;
                        if (r_sum_st != ST_OK || s_fr >= r_sum_faces
                                || {1'b0, s_fr} >= 9'(NF_LIM)) begin
                            n_ovalid   = 1'b1;
                            n_o_status = ST_NO_FACE;
                            n_o_fi     = s_fr;
                            n_o_pos    = '0;
                            n_o_fv     = '0;
                            n_o_adj    = '0;
                            n_o_ei     = '0;
                            n_o_fs     = '0;
                            n_o_last   = 1'b1;
                        end else begin
                            n_state = S_R_RS;
                        end
                    end
                end
            end
            // clear the slot stores of the vertices in use
            S_CLR: begin
                sf_we = 1'b1;
                sf_wa = r_k[SA-1:0];
                sf_wd = FACE_UNASSIGNED;
                se_we = 1'b1;
                se_wa = r_k[SA-1:0];
                se_wd = '0;
                n_k   = r_k + CNT_W'(1);
                if (r_k == three_n - CNT_W'(1)) begin
                    n_v     = '0;
                    n_state = S_CHK_RD;
                end
            end
            S_CHK_RD: begin
                nb_ra   = r_v[VA-1:0];
                n_state = S_CHK_CK;
            end
            S_CHK_CK: begin
                if ({1'b0, r_nb_rd[7:0]} >= r_n || {1'b0, r_nb_rd[15:8]} >= r_n
                        || {1'b0, r_nb_rd[23:16]} >= r_n) begin
                    n_st    = ST_NO_BACK;
                    n_state = S_FIN;
                end else if (last_v) begin
                    n_v     = '0;
                    n_state = S_MAIN_RD;
                end else begin
                    n_v     = r_v + 9'd1;
                    n_state = S_CHK_RD;
                end
            end
            S_MAIN_RD: begin
                nb_ra   = r_v[VA-1:0];
                n_state = S_MAIN_GET;
            end
            S_MAIN_GET: begin
                n_nbv   = r_nb_rd;
                n_j     = 2'd0;
                n_state = S_USE;
            end
            S_USE: begin
                n_u = nb_byte(r_nbv, r_j);
                if (r_v < {1'b0, n_u}) begin
                    if (r_edges >= CNT_W'(ME_LIM)) begin
                        n_st    = ST_BAD_EDGES;
                        n_state = S_FIN;
                    end else begin
                        nb_ra   = n_u[VA-1:0];
                        n_state = S_NUM;
                    end
                end else begin
                    n_state = S_FCHK;
                end
            end
            // number the edge at both of its slots
            S_NUM: begin
                c_p = slot_find(r_nb_rd, r_v[7:0]);
                if (c_p == SLOT_NONE) begin
                    n_st    = ST_NO_BACK;
                    n_state = S_FIN;
                end else begin
                    se_we   = 1'b1;
                    se_wa   = slot_addr(r_v[7:0], r_j);
                    se_wd   = r_edges[8:0];
                    n_pos   = c_p;
                    n_state = S_NUM2;
                end
            end
            S_NUM2: begin
                se_we   = 1'b1;
                se_wa   = slot_addr(r_u, r_pos);
                se_wd   = r_edges[8:0];
                n_edges = r_edges + CNT_W'(1);
                n_state = S_FCHK;
            end
            S_FCHK: begin
                sf_ra   = slot_addr(r_v[7:0], r_j);
                n_state = S_FCHK2;
            end
            S_FCHK2: begin
                if (r_sf_rd == FACE_UNASSIGNED) begin
                    c_p = slot_find(r_nbv, r_u);
                    if ({1'b0, r_faces} >= 9'(NF_LIM)) begin
                        n_st    = ST_BAD_SIZE;
                        n_state = S_FIN;
                    end else if (c_p == SLOT_NONE) begin
                        n_st    = ST_NO_BACK;
                        n_state = S_FIN;
                    end else begin
                        n_a     = r_v[7:0];
                        n_b     = r_u;
                        n_pos   = c_p;
                        n_size  = '0;
                        n_state = S_W_LOOP;
                    end
                end else if (r_j == 2'd2) begin
                    if (last_v) begin
                        n_state = S_ECHK;
                    end else begin
                        n_v     = r_v + 9'd1;
                        n_state = S_MAIN_RD;
                    end
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_USE;
                end
            end
            // trace one face until it reaches an assigned slot
            S_W_LOOP: begin
                sf_ra   = slot_addr(r_a, r_pos);
                n_state = S_W_TEST;
            end
            S_W_TEST: begin
                if (r_sf_rd != FACE_UNASSIGNED) begin
                    if (r_size == SIZE_PENT || r_size == SIZE_HEX) begin
                        fs_we   = 1'b1;
                        fs_wa   = r_faces[FA-1:0];
                        fs_wd   = r_size;
                        n_faces = r_faces + 8'd1;
                        if (r_j == 2'd2) begin
                            if (last_v) begin
                                n_state = S_ECHK;
                            end else begin
                                n_v     = r_v + 9'd1;
                                n_state = S_MAIN_RD;
                            end
                        end else begin
                            n_j     = r_j + 2'd1;
                            n_state = S_USE;
                        end
                    end else begin
                        n_st    = ST_BAD_SIZE;
                        n_state = S_FIN;
                    end
                end else if (r_size == SIZE_HEX) begin
                    n_st    = ST_BAD_SIZE;
                    n_state = S_FIN;
                end else begin
                    fv_we   = 1'b1;
                    fv_wa   = face_addr(r_faces, r_size);
                    fv_wd   = r_a;
                    sf_we   = 1'b1;
                    sf_wa   = slot_addr(r_a, r_pos);
                    sf_wd   = r_faces;
                    n_size  = r_size + 3'd1;
                    nb_ra   = r_b[VA-1:0];
                    n_state = S_W_NB;
                end
            end
            S_W_NB: begin
                c_p = slot_find(r_nb_rd, r_a);
                if (c_p == SLOT_NONE) begin
                    n_st    = ST_NO_BACK;
                    n_state = S_FIN;
                end else begin
                    n_pos   = slot_next(c_p);
                    n_a     = r_b;
                    n_b     = nb_byte(r_nb_rd, slot_next(c_p));
                    n_state = S_W_LOOP;
                end
            end
            S_ECHK: begin
                if (r_edges != (three_n >> 1)) begin
                    n_st    = ST_BAD_EDGES;
                    n_state = S_FIN;
                end else if (r_faces == 8'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_f     = '0;
                    n_state = S_A_RS;
                end
            end
            // link every boundary position to the face across it
            S_A_RS: begin
                fs_ra   = r_f[FA-1:0];
                n_state = S_A_GS;
            end
            S_A_GS: begin
                n_s     = r_fs_rd;
                n_pj    = '0;
                n_state = S_A_RA;
            end
            S_A_RA: begin
                fv_ra   = face_addr(r_f, r_pj);
                n_state = S_A_RB;
            end
            S_A_RB: begin
                n_a     = r_fv_rd;
                fv_ra   = face_addr(r_f, pj_next);
                n_state = S_A_NB;
            end
            S_A_NB: begin
                n_b     = r_fv_rd;
                nb_ra   = r_fv_rd[VA-1:0];
                n_state = S_A_P;
            end
            S_A_P: begin
                c_p = slot_find(r_nb_rd, r_a);
                if (c_p == SLOT_NONE) begin
                    n_st    = ST_NO_BACK;
                    n_state = S_FIN;
                end else begin
                    sf_ra   = slot_addr(r_b, c_p);
                    n_state = S_A_W;
                end
            end
            S_A_W: begin
                fa_we = 1'b1;
                fa_wa = face_addr(r_f, r_pj);
                fa_wd = r_sf_rd;
                if (pj_next == 3'd0) begin
                    if (r_f + 8'd1 == r_faces) begin
                        n_state = S_FIN;
                    end else begin
                        n_f     = r_f + 8'd1;
                        n_state = S_A_RS;
                    end
                end else begin
                    n_pj    = pj_next;
                    n_state = S_A_RA;
                end
            end
            S_FIN: begin
                if (o_free) begin
                    n_sum_st    = r_st;
                    n_sum_faces = r_faces;
                    n_sum_edges = r_edges;
                    n_ovalid    = 1'b1;
                    n_o_status  = r_st;
                    n_o_fi      = '0;
                    n_o_pos     = '0;
                    n_o_fv      = '0;
                    n_o_adj     = '0;
                    n_o_ei      = '0;
                    n_o_fs      = '0;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // read run: one result per boundary position
            S_R_RS: begin
                fs_ra   = r_fr[FA-1:0];
                n_state = S_R_GS;
            end
            S_R_GS: begin
                n_s     = (r_fs_rd > SIZE_HEX) ? SIZE_HEX : r_fs_rd;
                n_pj    = '0;
                n_state = S_R_RA;
            end
            S_R_RA: begin
                fv_ra   = face_addr(r_fr, r_pj);
                fa_ra   = face_addr(r_fr, r_pj);
                n_state = S_R_RB;
            end
            S_R_RB: begin
                n_a     = r_fv_rd;
                n_adj   = r_fa_rd;
                fv_ra   = face_addr(r_fr, pj_next);
                n_state = S_R_NB;
            end
            S_R_NB: begin
                n_b     = r_fv_rd;
                nb_ra   = r_fv_rd[VA-1:0];
                n_state = S_R_P;
            end
            S_R_P: begin
                c_p = slot_find(r_nb_rd, r_a);
                if (c_p == SLOT_NONE) begin
                    n_ei    = '0;
                    n_state = S_R_OUT;
                end else begin
                    se_ra   = slot_addr(r_b, c_p);
                    n_state = S_R_E;
                end
            end
            S_R_E: begin
                n_ei    = r_se_rd;
                n_state = S_R_OUT;
            end
            S_R_OUT: begin
                if (o_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = ST_OK;
                    n_o_fi     = r_fr;
                    n_o_pos    = r_pj;
                    n_o_fv     = r_a;
                    n_o_adj    = r_adj;
                    n_o_ei     = r_ei;
                    n_o_fs     = r_s;
                    n_o_last   = (pj_next == 3'd0);
                    if (pj_next == 3'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pj    = pj_next;
                        n_state = S_R_RA;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {r_o_fs, r_o_ei, r_o_adj, r_o_fv, r_o_pos, r_o_fi,
                         r_sum_edges[8:0], r_sum_faces};

endmodule

>>> tb/dual_scoreboard.sv
// Scoreboard for the cubic planar dual builder: predicts builds and face reads.
// Depends on cpdb_pkg for the action and status codes.
`timescale 1ns / 100ps

import cpdb_pkg::*;

typedef struct {
    bit       act;
    bit [7:0] vidx;
    bit [7:0] nb0;
    bit [7:0] nb1;
    bit [7:0] nb2;
    bit       fin;
    bit [7:0] face;
} t_graph_op;

typedef struct {
    bit [2:0] status;
    bit [7:0] fcount;
    bit [8:0] ecount;
    bit [7:0] findex;
    bit [2:0] pos;
    bit [7:0] fvert;
    bit [7:0] adj;
    bit [8:0] eidx;
    bit [2:0] fsize;
    bit       last;
} t_dual_res;

class dual_scoreboard;
    localparam int NV = 256;
    localparam int NF = NV / 2 + 2;
    localparam int NE = 3 * NV / 2;
    localparam int NONE = -1;

    int        nbr[NV][3];
    int        slot_face[NV * 3];
    int        slot_edge[NV * 3];
    int        fc_vert[NF * 6];
    int        fc_adj[NF * 6];
    int        fc_size[NF];
    int        vcount;
    bit [2:0]  sum_status;
    int        sum_faces;
    int        sum_edges;
    t_dual_res pending_q[$];
    int        errors;

    function new();
        foreach (nbr[i, j]) nbr[i][j] = 0;
        foreach (slot_face[i]) slot_face[i] = NONE;
        foreach (slot_edge[i]) slot_edge[i] = 0;
        foreach (fc_vert[i]) begin
            fc_vert[i] = 0;
            fc_adj[i] = 0;
        end
        foreach (fc_size[i]) fc_size[i] = 0;
        vcount = 0;
        sum_status = ST_OK;
        sum_faces = 0;
        sum_edges = 0;
        errors = 0;
    endfunction

    function int find_slot(int owner, int target);
        for (int i = 0; i < 3; i++)
            if (nbr[owner][i] == target) return i;
        return 3;
    endfunction

    // trace one face counter-clockwise starting at directed edge a->b
    function bit [2:0] trace_face(int fid, int a, int b);
        int pos;
        int size;
        int q;
        int w;
        pos = find_slot(a, b);
        size = 0;
        if (pos == 3) return ST_NO_BACK;
        while (slot_face[a * 3 + pos] == NONE) begin
            if (size == 6) return ST_BAD_SIZE;
            fc_vert[fid * 6 + size] = a;
            size++;
            slot_face[a * 3 + pos] = fid;
            q = find_slot(b, a);
            if (q == 3) return ST_NO_BACK;
            pos = (q + 1) % 3;
            w = nbr[b][pos];
            a = b;
            b = w;
        end
        if (size != 5 && size != 6) return ST_BAD_SIZE;
        fc_size[fid] = size;
        return ST_OK;
    endfunction

    function void build_dual();
        int n;
        int u;
        int p;
        int s;
        int faces;
        int edges;
        bit [2:0] st;
        bit [2:0] r;
        n = vcount;
        faces = 0;
        edges = 0;
        st = ST_OK;
        foreach (slot_face[i]) begin
            slot_face[i] = NONE;
            slot_edge[i] = 0;
        end
        for (int v = 0; v < n; v++)
            for (int j = 0; j < 3; j++)
                if (nbr[v][j] >= n) st = ST_NO_BACK;
        for (int v = 0; v < n && st == ST_OK; v++) begin
            for (int j = 0; j < 3 && st == ST_OK; j++) begin
                u = nbr[v][j];
                if (v < u) begin
                    if (edges >= NE) begin
                        st = ST_BAD_EDGES;
                        break;
                    end
                    p = find_slot(u, v);
                    if (p == 3) begin
                        st = ST_NO_BACK;
                        break;
                    end
                    slot_edge[v * 3 + j] = edges;
                    slot_edge[u * 3 + p] = edges;
                    edges++;
                end
                if (slot_face[v * 3 + j] == NONE) begin
                    if (faces >= NF) begin
                        st = ST_BAD_SIZE;
                        break;
                    end
                    r = trace_face(faces, v, u);
                    if (r != ST_OK) begin
                        st = r;
                        break;
                    end
                    faces++;
                end
            end
        end
        if (st == ST_OK && edges != 3 * n / 2) st = ST_BAD_EDGES;
        for (int f = 0; f < faces && st == ST_OK; f++) begin
            s = fc_size[f];
            for (int j = 0; j < s; j++) begin
                p = find_slot(fc_vert[f * 6 + (j + 1) % s], fc_vert[f * 6 + j]);
                if (p == 3) begin
                    st = ST_NO_BACK;
                    break;
                end
                fc_adj[f * 6 + j] = slot_face[fc_vert[f * 6 + (j + 1) % s] * 3 + p];
            end
        end
        sum_status = st;
        sum_faces = faces;
        sum_edges = edges;
    endfunction

    function void push(bit [2:0] st, int fi, int ps, int fv, int af, int ei, int fs, bit last);
        t_dual_res r;
        r.status = st;
        r.fcount = 8'(sum_faces);
        r.ecount = 9'(sum_edges);
        r.findex = 8'(fi);
        r.pos = 3'(ps);
        r.fvert = 8'(fv);
        r.adj = 8'(af);
        r.eidx = 9'(ei);
        r.fsize = 3'(fs);
        r.last = last;
        pending_q.push_back(r);
    endfunction

    // note an accepted input transfer and queue the results it causes
    function void note_input(t_graph_op op);
        int s;
        int a;
        int b;
        int p;
        int ei;
        int fr;
        fr = int'(op.face);
        if (op.act == ACT_LOAD) begin
            nbr[op.vidx][0] = int'(op.nb0);
            nbr[op.vidx][1] = int'(op.nb1);
            nbr[op.vidx][2] = int'(op.nb2);
            vcount = int'(op.vidx) + 1;
            if (op.fin) begin
                build_dual();
                push(sum_status, 0, 0, 0, 0, 0, 0, 1'b1);
            end
            return;
        end
        if (sum_status != ST_OK || fr >= sum_faces || fr >= NF) begin
            push(ST_NO_FACE, fr, 0, 0, 0, 0, 0, 1'b1);
            return;
        end
        s = (fc_size[fr] > 6) ? 6 : fc_size[fr];
        for (int j = 0; j < s; j++) begin
            a = fc_vert[fr * 6 + j];
            b = fc_vert[fr * 6 + (j + 1) % s];
            p = find_slot(b, a);
            ei = (p != 3) ? slot_edge[b * 3 + p] : 0;
            push(ST_OK, fr, j, a, fc_adj[fr * 6 + j], ei, s, j + 1 == s);
        end
    endfunction

    task report(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        errors++;
    endtask

    task check_result(t_dual_res got);
        t_dual_res ex;
        string bad;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result status %0d face %0d", got.status, got.findex));
            return;
        end
        ex = pending_q.pop_front();
        bad = "";
        if (got.status !== ex.status) bad = {bad, " status"};
        if (got.fcount !== ex.fcount) bad = {bad, " face_count"};
        if (got.ecount !== ex.ecount) bad = {bad, " edge_count"};
        if (got.findex !== ex.findex) bad = {bad, " face_index"};
        if (got.pos !== ex.pos) bad = {bad, " position"};
        if (got.fvert !== ex.fvert) bad = {bad, " face_vertex"};
        if (got.adj !== ex.adj) bad = {bad, " adjacent_face"};
        if (got.eidx !== ex.eidx) bad = {bad, " edge_index"};
        if (got.fsize !== ex.fsize) bad = {bad, " face_len"};
        if (got.last !== ex.last) bad = {bad, " last"};
        if (bad != "")
            report($sformatf("face %0d pos %0d wrong:%s (exp st %0d v %0d adj %0d e %0d)",
                             ex.findex, ex.pos, bad, ex.status, ex.fvert, ex.adj, ex.eidx));
    endtask
endclass

>>> tb/testbench.sv
// Top-level testbench for cubic_planar_dual_builder: loads honeycomb-torus and
// dodecahedron graphs, damaged variants and noise, then reads faces. Uses dual_scoreboard.
`timescale 1ns / 100ps

module testbench;
    import cpdb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    dual_scoreboard sb = new();
    t_graph_op      stim_q[$];
    bit             written[256];
    int             accepted;

    cubic_planar_dual_builder DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_load(int v, int a, int b, int c, bit fin);
        t_graph_op op;
        op.act = ACT_LOAD;
        op.vidx = 8'(v);
        op.nb0 = 8'(a);
        op.nb1 = 8'(b);
        op.nb2 = 8'(c);
        op.fin = fin;
        op.face = 8'($urandom());
        written[v] = 1'b1;
        stim_q.push_back(op);
    endfunction

    function automatic void add_read(int f);
        t_graph_op op;
        op.act = ACT_READ;
        op.vidx = 8'($urandom());
        op.nb0 = 8'($urandom());
        op.nb1 = 8'($urandom());
        op.nb2 = 8'($urandom());
        op.fin = 1'($urandom());
        op.face = 8'(f);
        stim_q.push_back(op);
    endfunction

    // Send a graph in ascending order of relabeled vertex, with optional damage:
    // 1 stray neighbor, 2 one list mirrored, 3 final flag too early.
    function automatic void send_graph(int g[256][3], int n, bit shuffle, int damage);
        int perm[256];
        int inv[256];
        int t;
        int k;
        int rot;
        int v;
        int lst[3];
        int cut;
        int hit;
        for (int i = 0; i < n; i++) perm[i] = i;
        if (shuffle)
            for (int i = n - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                t = perm[i];
                perm[i] = perm[k];
                perm[k] = t;
            end
        for (int i = 0; i < n; i++) inv[perm[i]] = i;
        cut = (damage == 3) ? $urandom_range(0, n - 2) : n - 1;
        hit = $urandom_range(0, n - 1);
        for (int L = 0; L <= cut; L++) begin
            v = inv[L];
            rot = shuffle ? $urandom_range(0, 2) : 0;
            for (int j = 0; j < 3; j++) lst[j] = perm[g[v][(j + rot) % 3]];
            if (L == hit && damage == 1) lst[$urandom_range(0, 2)] = $urandom_range(0, 255);
            if (L == hit && damage == 2) begin
                t = lst[0];
                lst[0] = lst[1];
                lst[1] = t;
            end
            add_load(L, lst[0], lst[1], lst[2], L == cut);
        end
    endfunction

    function automatic void honeycomb(int w, int h, bit shuffle, int damage);
        int g[256][3];
        int v;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                v = y * w + x;
                g[v][0] = y * w + (x + w - 1) % w;
                if ((x + y) % 2 == 0) begin
                    g[v][1] = ((y + 1) % h) * w + x;
                    g[v][2] = y * w + (x + 1) % w;
                end else begin
                    g[v][1] = y * w + (x + 1) % w;
                    g[v][2] = ((y + h - 1) % h) * w + x;
                end
            end
        send_graph(g, w * h, shuffle, damage);
    endfunction

    // outer ring 0..4, middle ring 5..14, inner ring 15..19, lists clockwise
    function automatic void dodecahedron(bit shuffle, int damage);
        int g[256][3];
        int m;
        for (int i = 0; i < 5; i++) begin
            g[i] = '{(i + 1) % 5, (i + 4) % 5, 5 + 2 * i};
            g[15 + i] = '{15 + (i + 1) % 5, 5 + 2 * i + 1, 15 + (i + 4) % 5};
        end
        for (int k = 0; k < 10; k++) begin
            m = 5 + k;
            if (k % 2 == 0) g[m] = '{5 + (k + 1) % 10, k / 2, 5 + (k + 9) % 10};
            else g[m] = '{5 + (k + 1) % 10, 5 + (k + 9) % 10, 15 + (k - 1) / 2};
        end
        send_graph(g, 20, shuffle, damage);
    endfunction

    function automatic void make_stimulus();
        int sel;
        int v;
        bit fin;
        int ws[6] = '{4, 6, 8, 10, 12, 16};
        // directed: smallest torus, reads at the edges of the face range, two broken builds
        honeycomb(4, 2, 0, 0);
        add_read(0);
        add_read(3);
        add_read(4);
        add_read(129);
        add_read(255);
        add_load(0, 255, 255, 255, 1'b1);
        add_read(0);
        add_load(0, 0, 0, 0, 1'b1);
        add_read(0);
        while (stim_q.size() < 420) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) begin
                if ($urandom_range(0, 1)) dodecahedron(1, $urandom_range(0, 5) < 4 ? 0 :
                                                              $urandom_range(1, 3));
                else honeycomb(ws[$urandom_range(0, 5) == 0 ? 5 : $urandom_range(0, 3)],
                               2 * $urandom_range(1, 3), 1,
                               $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 3));
                repeat ($urandom_range(2, 8))
                    add_read($urandom_range(0, 9) < 8 ? $urandom_range(0, 35)
                                                      : $urandom_range(0, 255));
            end else if (sel < 18) begin
                // noise load: a final one only where every lower vertex was written
                v = $urandom_range(0, 255);
                fin = $urandom_range(0, 2) == 0;
                for (int i = 0; i < v; i++) if (!written[i]) fin = 0;
                add_load(v, $urandom(), $urandom(), $urandom(), fin);
            end else begin
                add_read($urandom_range(0, 255));
            end
        end
    endfunction

    task automatic drive_inputs();
        t_graph_op op;
        int gap;
        while (stim_q.size() != 0) begin
            op = stim_q.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tuser <= op.act;
            i_s_tlast <= op.fin;
            i_s_tdata <= {op.face, op.nb2, op.nb1, op.nb0, op.vidx};
            do @(posedge i_clk); while (!o_s_tready);
            gap = gap_len();
            if (gap != 0 || stim_q.size() == 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        bit held;
        held = 0;
        i_m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && accepted > 150) begin
                held = 1;
                i_m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (gap_len() != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_graph_op op;
        t_dual_res r;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            op.act = i_s_tuser;
            op.fin = i_s_tlast;
            {op.face, op.nb2, op.nb1, op.nb0, op.vidx} = i_s_tdata;
            sb.note_input(op);
            accepted++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            r.status = o_m_tuser;
            r.last = o_m_tlast;
            {r.fsize, r.eidx, r.adj, r.fvert, r.pos, r.findex, r.ecount, r.fcount} = o_m_tdata;
            sb.check_result(r);
        end
    end

    initial begin
        int waited;
        accepted = 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser <= 1'b0;
        i_s_tlast <= 1'b0;
        i_s_tdata <= '0;
        make_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_inputs();
        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending_q.size() != 0) sb.report("results still outstanding at end of run");
        // allow a late stray result to show up
        repeat (6000) @(posedge i_clk);
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

>>> sim.f
sv/cpdb_pkg.sv
sv/cubic_planar_dual_builder.sv
tb/dual_scoreboard.sv
tb/testbench.sv
